@@ rtl/core/csvt_pkg.sv @@
package csvt_pkg;

  // Result kinds on the output channel
  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_FIELD = 3'd1,
    KIND_ROW   = 3'd2,
    KIND_ERROR = 3'd3,
    KIND_DONE  = 3'd4
  } kind_t;

  // Request types on the input channel
  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam int CODE_W = 16;

  // Text constants
  localparam logic [CODE_W-1:0] CH_QUOTE = 16'h0022;
  localparam logic [CODE_W-1:0] CH_COMMA = 16'h002C;
  localparam logic [CODE_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CODE_W-1:0] CH_LF    = 16'h000A;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queued command: first result kind, plus a flag for a trailing done result
  typedef struct packed {
    kind_t kind;
    logic  two;
  } cmd_t;

endpackage

@@ rtl/core/csvt_in_if.sv @@
interface csvt_in_if;
  import csvt_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CODE_W-1:0] code_unit;

  modport source (output valid, output req_type, output code_unit, input ready);
  modport sink   (input valid, input req_type, input code_unit, output ready);
endinterface

@@ rtl/core/csvt_out_if.sv @@
interface csvt_out_if;
  import csvt_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        out_kind;
  logic [CODE_W-1:0] out_char;
  logic              last;

  modport source (output valid, output out_kind, output out_char, output last, input ready);
  modport sink   (input valid, input out_kind, input out_char, input last, output ready);
endinterface

@@ rtl/core/csvt_front.sv @@
module csvt_front
  import csvt_pkg::*;
#(
  parameter int CHAR_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  csvt_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_cmd,
  output logic [CHAR_W-1:0] push_char
);

  logic in_quotes_r, in_quotes_nxt;
  logic quote_pending_r, quote_pending_nxt;
  logic field_empty_r, field_empty_nxt;
  logic row_has_fields_r, row_has_fields_nxt;

  logic              fire;
  logic [CHAR_W-1:0] c;
  logic              is_end;
  logic              lit_quote;
  logic              iq;
  logic              emit;
  cmd_t              cmd;
  logic [CHAR_W-1:0] ch;

  assign in_ch.ready = ~q_full;
  assign fire        = in_ch.valid & ~q_full;
  assign c           = in_ch.code_unit[CHAR_W-1:0];
  assign is_end      = (in_ch.req_type == REQ_END) || (c == '0);
  assign lit_quote   = quote_pending_r & ~is_end & (c == CHAR_W'(CH_QUOTE));
  // a pending quote that is not doubled closes quoting first
  assign iq          = in_quotes_r & ~quote_pending_r;

  always_comb begin
    in_quotes_nxt      = in_quotes_r;
    quote_pending_nxt  = 1'b0;
    field_empty_nxt    = field_empty_r;
    row_has_fields_nxt = row_has_fields_r;
    emit               = 1'b0;
    cmd.kind           = KIND_CHAR;
    cmd.two            = 1'b0;
    ch                 = '0;
    if (lit_quote) begin
      field_empty_nxt = 1'b0;
      emit            = 1'b1;
      ch              = CHAR_W'(CH_QUOTE);
    end else if (is_end) begin
      emit = 1'b1;
      if (iq) begin
        cmd.kind = KIND_ERROR;
      end else if (~field_empty_r | row_has_fields_r) begin
        cmd.kind = KIND_ROW;
        cmd.two  = 1'b1;
      end else begin
        cmd.kind = KIND_DONE;
      end
      in_quotes_nxt      = 1'b0;
      field_empty_nxt    = 1'b1;
      row_has_fields_nxt = 1'b0;
    end else if (iq) begin
      in_quotes_nxt = 1'b1;
      if (c == CHAR_W'(CH_QUOTE)) begin
        quote_pending_nxt = 1'b1;
      end else begin
        field_empty_nxt = 1'b0;
        emit            = 1'b1;
        ch              = c;
      end
    end else begin
      in_quotes_nxt = 1'b0;
      if (c == CHAR_W'(CH_QUOTE) && field_empty_r) begin
        in_quotes_nxt = 1'b1;
      end else if (c == CHAR_W'(CH_COMMA)) begin
        emit               = 1'b1;
        cmd.kind           = KIND_FIELD;
        field_empty_nxt    = 1'b1;
        row_has_fields_nxt = 1'b1;
      end else if (c == CHAR_W'(CH_CR)) begin
        // drop
      end else if (c == CHAR_W'(CH_LF)) begin
        emit               = 1'b1;
        cmd.kind           = KIND_ROW;
        field_empty_nxt    = 1'b1;
        row_has_fields_nxt = 1'b0;
      end else begin
        field_empty_nxt = 1'b0;
        emit            = 1'b1;
        ch              = c;
      end
    end
  end

  assign push      = fire & emit;
  assign push_cmd  = cmd;
  assign push_char = ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r      <= 1'b0;
      quote_pending_r  <= 1'b0;
      field_empty_r    <= 1'b1;
      row_has_fields_r <= 1'b0;
    end else if (fire) begin
      in_quotes_r      <= in_quotes_nxt;
      quote_pending_r  <= quote_pending_nxt;
      field_empty_r    <= field_empty_nxt;
      row_has_fields_r <= row_has_fields_nxt;
    end
  end

endmodule

@@ rtl/core/csvt_fifo.sv @@
module csvt_fifo
  import csvt_pkg::*;
#(
  parameter int CHAR_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cmd_t              push_cmd,
  input  logic [CHAR_W-1:0] push_char,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output cmd_t              head_cmd,
  output logic [CHAR_W-1:0] head_char
);

  cmd_t              cmd_mem  [QUEUE_DEPTH];
  logic [CHAR_W-1:0] char_mem [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign head_cmd  = cmd_mem[rd_ptr_r];
  assign head_char = char_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_mem[wr_ptr_r]  <= push_cmd;
      char_mem[wr_ptr_r] <= push_char;
    end
  end

endmodule

@@ rtl/core/csvt_back.sv @@
module csvt_back
  import csvt_pkg::*;
#(
  parameter int CHAR_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              head_cmd,
  input  logic [CHAR_W-1:0] head_char,
  output logic              pop,
  csvt_out_if.source        out_ch
);

  // second result of a two-result command is pending
  logic phase_r, phase_nxt;
  logic fire;
  logic is_last;

  assign is_last         = phase_r | ~head_cmd.two;
  assign out_ch.valid    = ~q_empty;
  assign out_ch.out_kind = phase_r ? KIND_DONE : head_cmd.kind;
  assign out_ch.out_char = phase_r ? '0 : CODE_W'(head_char);
  assign out_ch.last     = is_last;
  assign fire            = out_ch.valid & out_ch.ready;
  assign pop             = fire & is_last;

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      phase_nxt = ~is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ rtl/core/csv_field_tokenizer_core.sv @@
// An item accepted into an empty queue shows its first result in the next cycle.
// Throughput: one item per cycle while the queue has space; an item that ends a row at end
// of content produces two results (row end, then done). Items with no result queue nothing.
// A four-entry command queue sits between the classifier and the result sequencer.
// Reset: synchronous, active low; clears the quote/field/row flags and empties the queue.
module csv_field_tokenizer_core
  import csvt_pkg::*;
#(
  parameter int CHAR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  csvt_in_if.sink    in_ch,
  csvt_out_if.source out_ch
);

  // Code units are masked to CHAR_BITS, and never beyond the 16-bit channel.
  localparam int CHAR_W = (CHAR_BITS < CODE_W) ? CHAR_BITS : CODE_W;

  logic              push;
  cmd_t              push_cmd;
  logic [CHAR_W-1:0] push_char;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  cmd_t              head_cmd;
  logic [CHAR_W-1:0] head_char;

  // Front: accept each item, update the tokenizer flags, queue a command when
  // the item produces results. Ready follows only queue space.
  csvt_front #(.CHAR_W(CHAR_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_char (push_char)
  );

  // Queue: decouple the classifier from output backpressure.
  csvt_fifo #(.CHAR_W(CHAR_W)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_char (push_char),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_cmd  (head_cmd),
    .head_char (head_char)
  );

  // Back: expand each command into one or two result items and mark the last.
  csvt_back #(.CHAR_W(CHAR_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_cmd  (head_cmd),
    .head_char (head_char),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // A row end that is not last must be followed by done once taken.
  a_row_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.out_kind == KIND_ROW && !out_ch.last
    |=> out_ch.valid && out_ch.out_kind == KIND_DONE && out_ch.last)
    else $error("row end not followed by done");

  // Only character results carry a character.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_kind != KIND_CHAR |-> out_ch.out_char == '0)
    else $error("nonzero char on non-character result");

  // Character, error, field and done results are always the last of their item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.out_kind == KIND_ERROR || out_ch.out_kind == KIND_DONE ||
                     out_ch.out_kind == KIND_FIELD || out_ch.out_kind == KIND_CHAR)
    |-> out_ch.last)
    else $error("single result not marked last");

  // Queue space and input ready agree.
  a_ready_space: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !q_full)
    else $error("item accepted into a full queue");

endmodule
